// ----- hdl/wcsb_pkg.sv -----
// ---------------------------------------------------------------------------
// wcsb_pkg
// Shared types and constants of the write coalescing slot buffer.
// ---------------------------------------------------------------------------
`default_nettype none

package wcsb_pkg;

  localparam int UNIT_COUNT      = 4;
  localparam int SLOTS_PER_UNIT  = 4;
  localparam int SLOT_INDEX_BITS = 2;

  localparam int LPN_W    = 32;
  localparam int OP_W     = 2;
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 2;
  localparam int UNIT_W   = 2;
  localparam int FILL_W   = 3;
  // unit count is a power of two; the unit is a field of the lpn
  localparam int UNIT_BITS = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;

  localparam logic [LPN_W-1:0] EMPTY_LPN = '1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_INVAL  = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PLACED = 2'd0,
    KIND_FLUSH  = 2'd1,
    KIND_INVAL  = 2'd2,
    KIND_LOOKUP = 2'd3
  } kind_t;

  typedef logic [SLOTS_PER_UNIT-1:0][LPN_W-1:0] row_t;

endpackage

`default_nettype wire

// ----- hdl/wcsb_if.sv -----
// ---------------------------------------------------------------------------
// wcsb_if
// Request and result channels of the write coalescing slot buffer.
// ---------------------------------------------------------------------------
`default_nettype none

interface wcsb_in_if;
  logic                      valid;
  logic                      ready;
  logic [wcsb_pkg::OP_W-1:0]  operation;
  logic [wcsb_pkg::LPN_W-1:0] lpn;

  modport source (output valid, operation, lpn, input ready);
  modport sink   (input valid, operation, lpn, output ready);
endinterface

interface wcsb_out_if;
  logic                        valid;
  logic                        ready;
  logic [wcsb_pkg::KIND_W-1:0] kind;
  logic                        hit;
  logic [wcsb_pkg::SLOT_W-1:0] slot;
  logic [wcsb_pkg::LPN_W-1:0]  page_lpn;
  logic [wcsb_pkg::UNIT_W-1:0] unit;
  logic [wcsb_pkg::FILL_W-1:0] fill_count;
  logic                        last;

  modport source (output valid, kind, hit, slot, page_lpn, unit, fill_count, last,
                  input ready);
  modport sink   (input valid, kind, hit, slot, page_lpn, unit, fill_count, last,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/write_coalescing_slot_buffer_core.sv -----
// ---------------------------------------------------------------------------
// write_coalescing_slot_buffer_core
// Per-unit write coalescing buffer: slot rows held in one row-wide RAM,
// read, modified and written back once per request but OP_NONE; full rows are flushed.
// ---------------------------------------------------------------------------
//  channel | dir | words
//  in_ch   | in  | operation, lpn
//  out_ch  | out | kind, hit, slot, page_lpn, unit, fill_count, last
//
//  A request is handled as a RAM row read, then a modify and write back.
//  A flushing write holds the input for SLOTS_PER_UNIT further result words.
//  Reset clears per-row valid flags at once; an unwritten row reads empty.
//  A stalled output register holds the request in its update cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module write_coalescing_slot_buffer_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  wcsb_in_if.sink     in_ch,
  wcsb_out_if.source  out_ch
);
  import wcsb_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_FLUSH} state_t;

  state_t                     state_r, state_nxt;
  op_t                        op_r, op_nxt;
  logic [LPN_W-1:0]           lpn_r, lpn_nxt;
  logic [UNIT_BITS-1:0]       unit_r, unit_nxt;
  logic [UNIT_COUNT-1:0]      row_ok_r, row_ok_nxt;
  row_t                       flush_row_r, flush_row_nxt;
  logic [SLOT_INDEX_BITS-1:0] fl_idx_r, fl_idx_nxt;

  logic                       out_valid_r, out_valid_nxt;
  kind_t                      out_kind_r, out_kind_nxt;
  logic                       out_hit_r, out_hit_nxt;
  logic [SLOT_W-1:0]          out_slot_r, out_slot_nxt;
  logic [LPN_W-1:0]           out_page_r, out_page_nxt;
  logic [UNIT_W-1:0]          out_unit_r, out_unit_nxt;
  logic [FILL_W-1:0]          out_fill_r, out_fill_nxt;
  logic                       out_last_r, out_last_nxt;

  row_t                       mem [UNIT_COUNT];
  row_t                       rd_row_r;
  logic                       mem_we;
  row_t                       mem_wd;
  logic                       mem_re;

  row_t                       row_cur, row_new;
  logic [SLOTS_PER_UNIT-1:0]  match_v, empty_v, inr_v;
  logic                       any_match, any_empty, lpn_real;
  logic [SLOT_INDEX_BITS-1:0] match_idx, free_idx;
  logic [FILL_W-1:0]          occ;
  logic [LPN_W:0]             diff;
  logic                       out_free, do_flush;
  logic                       res_hit;
  logic [SLOT_INDEX_BITS-1:0] res_slot;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.slot       = out_slot_r;
  assign out_ch.page_lpn   = out_page_r;
  assign out_ch.unit       = out_unit_r;
  assign out_ch.fill_count = out_fill_r;
  assign out_ch.last       = out_last_r;

  assign out_free = !out_valid_r || out_ch.ready;
  assign mem_re   = in_ch.valid && (state_r == ST_IDLE);

  // row RAM, one row per unit
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[unit_r] <= mem_wd;
    end
    if (mem_re) begin
      rd_row_r <= mem[in_ch.lpn[SLOT_INDEX_BITS +: UNIT_BITS]];
    end
  end

  // row search and update
  always_comb begin
    row_cur  = row_ok_r[unit_r] ? rd_row_r : {SLOTS_PER_UNIT{EMPTY_LPN}};
    lpn_real = (lpn_r != EMPTY_LPN);
    for (int i = 0; i < SLOTS_PER_UNIT; i++) begin
      match_v[i] = lpn_real && (row_cur[i] == lpn_r);
      empty_v[i] = (row_cur[i] == EMPTY_LPN);
      diff       = {1'b0, row_cur[i]} - {1'b0, lpn_r};
      inr_v[i]   = !empty_v[i] && !diff[LPN_W] &&
                   (diff[LPN_W-1:0] < LPN_W'(SLOTS_PER_UNIT));
    end
    any_match = |match_v;
    any_empty = |empty_v;
    match_idx = '0;
    free_idx  = '0;
    for (int i = SLOTS_PER_UNIT - 1; i >= 0; i--) begin
      if (match_v[i]) match_idx = SLOT_INDEX_BITS'(i);
      if (empty_v[i]) free_idx  = SLOT_INDEX_BITS'(i);
    end

    row_new  = row_cur;
    res_hit  = 1'b0;
    res_slot = '0;
    case (op_r)
      OP_WRITE: begin
        res_hit = any_match;
        if (any_match) begin
          res_slot = match_idx;
        end else if (lpn_real && any_empty) begin
          res_slot          = free_idx;
          row_new[free_idx] = lpn_r;
        end
      end
      OP_INVAL: begin
        res_hit = |inr_v;
        for (int i = 0; i < SLOTS_PER_UNIT; i++) begin
          if (inr_v[i]) row_new[i] = EMPTY_LPN;
        end
      end
      OP_LOOKUP: begin
        res_hit  = any_match;
        res_slot = any_match ? match_idx : '0;
      end
      default: ;
    endcase

    occ = '0;
    for (int i = 0; i < SLOTS_PER_UNIT; i++) begin
      occ = occ + FILL_W'(row_new[i] != EMPTY_LPN);
    end
    do_flush = (op_r == OP_WRITE) && (occ == FILL_W'(SLOTS_PER_UNIT));
  end

  // control and result word
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    lpn_nxt       = lpn_r;
    unit_nxt      = unit_r;
    row_ok_nxt    = row_ok_r;
    flush_row_nxt = flush_row_r;
    fl_idx_nxt    = fl_idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_hit_nxt   = out_hit_r;
    out_slot_nxt  = out_slot_r;
    out_page_nxt  = out_page_r;
    out_unit_nxt  = out_unit_r;
    out_fill_nxt  = out_fill_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_wd        = row_new;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = op_t'(in_ch.operation);
          lpn_nxt   = in_ch.lpn;
          unit_nxt  = in_ch.lpn[SLOT_INDEX_BITS +: UNIT_BITS];
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (op_r == OP_NONE) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          mem_we               = 1'b1;
          row_ok_nxt[unit_r]   = 1'b1;
          out_valid_nxt        = 1'b1;
          out_hit_nxt          = res_hit;
          out_slot_nxt         = SLOT_W'(res_slot);
          out_page_nxt         = '0;
          out_unit_nxt         = UNIT_W'(unit_r);
          out_fill_nxt         = do_flush ? '0 : occ;
          out_last_nxt         = !do_flush;
          unique case (op_r)
            OP_WRITE: out_kind_nxt = KIND_PLACED;
            OP_INVAL: out_kind_nxt = KIND_INVAL;
            default:  out_kind_nxt = KIND_LOOKUP;
          endcase
          if (do_flush) begin
            mem_wd        = {SLOTS_PER_UNIT{EMPTY_LPN}};
            flush_row_nxt = row_new;
            fl_idx_nxt    = '0;
            state_nxt     = ST_FLUSH;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FLUSH;
          out_hit_nxt   = 1'b0;
          out_slot_nxt  = SLOT_W'(fl_idx_r);
          out_page_nxt  = flush_row_r[fl_idx_r];
          out_unit_nxt  = UNIT_W'(unit_r);
          out_fill_nxt  = '0;
          out_last_nxt  = (fl_idx_r == SLOT_INDEX_BITS'(SLOTS_PER_UNIT - 1));
          fl_idx_nxt    = fl_idx_r + SLOT_INDEX_BITS'(1);
          if (fl_idx_r == SLOT_INDEX_BITS'(SLOTS_PER_UNIT - 1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_ok_r    <= '0;
      out_valid_r <= 1'b0;
      fl_idx_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      row_ok_r    <= row_ok_nxt;
      out_valid_r <= out_valid_nxt;
      fl_idx_r    <= fl_idx_nxt;
    end
    op_r        <= op_nxt;
    lpn_r       <= lpn_nxt;
    unit_r      <= unit_nxt;
    flush_row_r <= flush_row_nxt;
    out_kind_r  <= out_kind_nxt;
    out_hit_r   <= out_hit_nxt;
    out_slot_r  <= out_slot_nxt;
    out_page_r  <= out_page_nxt;
    out_unit_r  <= out_unit_nxt;
    out_fill_r  <= out_fill_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

`default_nettype wire

// ----- bench/tb_write_coalescing_slot_buffer_core.sv -----
// ---------------------------------------------------------------------------
// tb_write_coalescing_slot_buffer_core
// Self-checking bench for the write coalescing slot buffer. A directed table
// covers reset state, the empty marker, ignored operations, flushes and
// unaligned invalidates. Random traffic on a small lpn pool follows, under
// several idle and stall mixes and one long receiver hold-off. Every result
// word is compared with a behavioural prediction of the slot rows or, for
// the literal rows of the directed table, with their literal expected word.
`default_nettype none

module tb_write_coalescing_slot_buffer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import wcsb_pkg::*;

  typedef logic [LPN_W-1:0] lpn_t;

  typedef struct packed {
    kind_t              kind;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [LPN_W-1:0]   page_lpn;
    logic [UNIT_W-1:0]  unit;
    logic [FILL_W-1:0]  fill_count;
    logic               last;
  } result_word_t;

  typedef struct {
    op_t          op;
    lpn_t         lpn;
    bit           typed;
    result_word_t word;
  } stim_row_t;

  localparam int LOW_W          = SLOT_INDEX_BITS + UNIT_BITS;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int NUM_PHASES     = 5;
  localparam int PHASE_SEND_IDLE [NUM_PHASES] = '{0, 76, 0, 35, 0};
  localparam int PHASE_RECV_STALL[NUM_PHASES] = '{0, 0, 76, 35, 0};
  localparam int PHASE_ITEMS     [NUM_PHASES] = '{50, 50, 50, 50, 40};

  logic clk = 1'b0;
  logic rst_n;

  wcsb_in_if  in_ch ();
  wcsb_out_if out_ch ();

  write_coalescing_slot_buffer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // predicted slot rows and fill counts
  lpn_t         row_lpns [UNIT_COUNT*SLOTS_PER_UNIT];
  int unsigned  row_fill [UNIT_COUNT];
  result_word_t expected_words [$];

  int  mismatches    = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_armed    = 1'b0;
  bit  hold_done     = 1'b0;
  int  hold_left     = 0;
  int  quiet_cycles  = 0;
  logic [LPN_W-LOW_W-1:0] lpn_bases [3];

  function automatic result_word_t mk_word(kind_t kind, logic hit, int slot, lpn_t page,
                                           int unit, int fill, logic last);
    result_word_t w;
    w.kind       = kind;
    w.hit        = hit;
    w.slot       = SLOT_W'(slot);
    w.page_lpn   = page;
    w.unit       = UNIT_W'(unit);
    w.fill_count = FILL_W'(fill);
    w.last       = last;
    return w;
  endfunction

  function automatic void reset_rows();
    for (int i = 0; i < UNIT_COUNT*SLOTS_PER_UNIT; i++) row_lpns[i] = EMPTY_LPN;
    for (int i = 0; i < UNIT_COUNT; i++) row_fill[i] = 0;
  endfunction

  function automatic void predict_words(op_t op, lpn_t lpn);
    int unsigned  u;
    int unsigned  base;
    logic         hit;
    int           slot;
    bit           placed;
    logic [LPN_W:0] lo;
    logic [LPN_W:0] hi;
    result_word_t burst [$];
    u      = (lpn >> SLOT_INDEX_BITS) % UNIT_COUNT;
    base   = u * SLOTS_PER_UNIT;
    hit    = 1'b0;
    slot   = 0;
    placed = 1'b0;
    case (op)
      OP_WRITE: begin
        if (lpn != EMPTY_LPN) begin
          for (int i = 0; i < SLOTS_PER_UNIT; i++)
            if (!hit && row_lpns[base+i] == lpn) begin
              hit  = 1'b1;
              slot = i;
            end
          if (!hit)
            for (int i = 0; i < SLOTS_PER_UNIT; i++)
              if (!placed && row_lpns[base+i] == EMPTY_LPN) begin
                row_lpns[base+i] = lpn;
                row_fill[u]++;
                slot   = i;
                placed = 1'b1;
              end
        end
        burst.push_back(mk_word(KIND_PLACED, hit, slot, '0, u, 0, 1'b0));
        if (row_fill[u] >= SLOTS_PER_UNIT) begin
          for (int i = 0; i < SLOTS_PER_UNIT; i++) begin
            burst.push_back(mk_word(KIND_FLUSH, 1'b0, i, row_lpns[base+i], u, 0, 1'b0));
            row_lpns[base+i] = EMPTY_LPN;
          end
          row_fill[u] = 0;
        end
      end
      OP_INVAL: begin
        lo = {1'b0, lpn};
        hi = lo + (LPN_W+1)'(SLOTS_PER_UNIT);
        for (int i = 0; i < SLOTS_PER_UNIT; i++)
          if (row_lpns[base+i] != EMPTY_LPN && {1'b0, row_lpns[base+i]} >= lo &&
              {1'b0, row_lpns[base+i]} < hi) begin
            row_lpns[base+i] = EMPTY_LPN;
            if (row_fill[u] > 0) row_fill[u]--;
            hit = 1'b1;
          end
        burst.push_back(mk_word(KIND_INVAL, hit, 0, '0, u, 0, 1'b0));
      end
      OP_LOOKUP: begin
        if (lpn != EMPTY_LPN)
          for (int i = 0; i < SLOTS_PER_UNIT; i++)
            if (!hit && row_lpns[base+i] == lpn) begin
              hit  = 1'b1;
              slot = i;
            end
        burst.push_back(mk_word(KIND_LOOKUP, hit, slot, '0, u, 0, 1'b0));
      end
      default: return;
    endcase
    foreach (burst[i]) begin
      burst[i].fill_count = FILL_W'(row_fill[u]);
      burst[i].last       = (i == burst.size() - 1);
      expected_words.push_back(burst[i]);
    end
  endfunction

  function automatic stim_row_t pred(op_t op, lpn_t lpn);
    stim_row_t r;
    r.op    = op;
    r.lpn   = lpn;
    r.typed = 1'b0;
    r.word  = '0;
    return r;
  endfunction

  function automatic stim_row_t lit(op_t op, lpn_t lpn, kind_t kind, logic hit, int slot,
                                    int unit, int fill);
    stim_row_t r;
    r.op    = op;
    r.lpn   = lpn;
    r.typed = 1'b1;
    r.word  = mk_word(kind, hit, slot, '0, unit, fill, 1'b1);
    return r;
  endfunction

  function automatic lpn_t rand_lpn();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return lpn_t'($urandom);
    if (pick < 12) return EMPTY_LPN - lpn_t'($urandom_range(0, 7));
    return {lpn_bases[$urandom_range(0, 2)], LOW_W'($urandom_range(0, (1 << LOW_W) - 1))};
  endfunction

  task automatic send_word(op_t op, lpn_t lpn);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.lpn       <= lpn;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [LPN_W-1:0] want, logic [LPN_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (hold_armed && !hold_done) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    result_word_t w;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: kind 0x%0h lpn 0x%0h",
               out_ch.kind, out_ch.page_lpn);
        mismatches++;
      end else begin
        w = expected_words.pop_front();
        check_field("kind",       LPN_W'(w.kind),       LPN_W'(out_ch.kind));
        check_field("hit",        LPN_W'(w.hit),        LPN_W'(out_ch.hit));
        check_field("slot",       LPN_W'(w.slot),       LPN_W'(out_ch.slot));
        check_field("page_lpn",   w.page_lpn,           out_ch.page_lpn);
        check_field("unit",       LPN_W'(w.unit),       LPN_W'(out_ch.unit));
        check_field("fill_count", LPN_W'(w.fill_count), LPN_W'(out_ch.fill_count));
        check_field("last",       LPN_W'(w.last),       LPN_W'(out_ch.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb_write_coalescing_slot_buffer_core NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t directed_rows [$];
    op_t       op;
    lpn_t      lpn;
    int        sent;
    int        r;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_WRITE;
    in_ch.lpn       = '0;
    out_ch.ready    = 1'b0;
    reset_rows();

    directed_rows = '{
      lit (OP_LOOKUP, 32'h0000_0000, KIND_LOOKUP, 1'b0, 0, 0, 0),
      lit (OP_LOOKUP, EMPTY_LPN,     KIND_LOOKUP, 1'b0, 0, 3, 0),
      lit (OP_WRITE,  EMPTY_LPN,     KIND_PLACED, 1'b0, 0, 3, 0),
      lit (OP_INVAL,  EMPTY_LPN,     KIND_INVAL,  1'b0, 0, 3, 0),
      pred(OP_NONE,   EMPTY_LPN),
      lit (OP_WRITE,  32'h0000_0000, KIND_PLACED, 1'b0, 0, 0, 1),
      lit (OP_WRITE,  32'h0000_0000, KIND_PLACED, 1'b1, 0, 0, 1),
      lit (OP_LOOKUP, 32'h0000_0000, KIND_LOOKUP, 1'b1, 0, 0, 1),
      pred(OP_WRITE,  32'h0000_0001),
      pred(OP_WRITE,  32'h0000_0002),
      pred(OP_WRITE,  32'h0000_0003),
      pred(OP_WRITE,  32'hFFFF_FFFE),
      pred(OP_WRITE,  32'hFFFF_FFFC),
      pred(OP_WRITE,  32'hFFFF_FFFD),
      pred(OP_INVAL,  32'hFFFF_FFFD),
      pred(OP_LOOKUP, 32'hFFFF_FFFC),
      pred(OP_WRITE,  32'h0000_0010),
      pred(OP_INVAL,  32'h0000_000E),
      pred(OP_LOOKUP, 32'h0000_0010),
      pred(OP_WRITE,  32'h0000_0004),
      pred(OP_WRITE,  32'h0000_0014),
      pred(OP_WRITE,  32'h0000_0024),
      pred(OP_INVAL,  32'h0000_0004),
      pred(OP_LOOKUP, 32'h0000_0024),
      pred(OP_WRITE,  32'h8000_0000)
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].op, directed_rows[i].lpn);
      predict_words(directed_rows[i].op, directed_rows[i].lpn);
      if (directed_rows[i].typed)
        expected_words[expected_words.size() - 1] = directed_rows[i].word;
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct   = PHASE_SEND_IDLE[p];
      recv_stall_pct <= PHASE_RECV_STALL[p];
      if (p == NUM_PHASES - 1) hold_armed <= 1'b1;
      foreach (lpn_bases[k]) lpn_bases[k] = (LPN_W-LOW_W)'($urandom);
      sent = 0;
      while (sent < PHASE_ITEMS[p]) begin
        r   = $urandom_range(0, 99);
        lpn = rand_lpn();
        if (r < 55) op = OP_WRITE;
        else if (r < 70) op = OP_INVAL;
        else if (r < 95) op = OP_LOOKUP;
        else op = OP_NONE;
        if (op == OP_INVAL && $urandom_range(0, 1) == 1)
          lpn = lpn & ~lpn_t'(SLOTS_PER_UNIT - 1);
        send_word(op, lpn);
        predict_words(op, lpn);
        if (op != OP_NONE) sent++;
      end
    end

    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_write_coalescing_slot_buffer_core OK");
    end else begin
      $display("tb_write_coalescing_slot_buffer_core NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
